// ===== rtl/twid_pkg.sv =====
// Shared types and codes for the two-word immediate op decoder.
package twid_pkg;

    // APB register map: byte address 4*index, word index in paddr[2]
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_XG3_MODE = 1'd0;

    // Operation classes
    localparam logic [4:0] CLS_INVALID  = 5'd0;
    localparam logic [4:0] CLS_LDI      = 5'd1;
    localparam logic [4:0] CLS_ADD      = 5'd2;
    localparam logic [4:0] CLS_XMOVTT   = 5'd3;
    localparam logic [4:0] CLS_LDISH16  = 5'd4;
    localparam logic [4:0] CLS_FLDCH    = 5'd5;
    localparam logic [4:0] CLS_BREAK    = 5'd6;
    localparam logic [4:0] CLS_FLDCF    = 5'd7;
    localparam logic [4:0] CLS_MOVQ_ST  = 5'd11;
    localparam logic [4:0] CLS_MOVL_ST  = 5'd12;
    localparam logic [4:0] CLS_LEAQ     = 5'd13;
    localparam logic [4:0] CLS_MOVQ_LD  = 5'd14;
    localparam logic [4:0] CLS_MOVL_LD  = 5'd15;
    localparam logic [4:0] CLS_BRA      = 5'd16;
    localparam logic [4:0] CLS_BSR      = 5'd17;

    // Operand forms
    localparam logic [2:0] FORM_IMM_REG = 3'd0;
    localparam logic [2:0] FORM_STORE   = 3'd1;
    localparam logic [2:0] FORM_LOAD    = 3'd2;
    localparam logic [2:0] FORM_PC_DISP = 3'd3;
    localparam logic [2:0] FORM_NONE    = 3'd4;

    // Predicate modes
    localparam logic [1:0] PRED_NONE  = 2'd0;
    localparam logic [1:0] PRED_TRUE  = 2'd1;
    localparam logic [1:0] PRED_FALSE = 2'd2;

    // Scheduling flag values
    localparam logic [3:0] FL_NONE     = 4'h0;
    localparam logic [3:0] FL_CTRL     = 4'h1;
    localparam logic [3:0] FL_NOWEX    = 4'h2;
    localparam logic [3:0] FL_BRANCH   = 4'h7;
    localparam logic [3:0] FL_NOWEX_IO = 4'h8;

    // Register number that turns FLDCH into a break
    localparam logic [4:0] RN_BREAK = 5'd15;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [31:0] jumbo_bits;
        logic        predicated_form;
        logic [47:0] pc_in;
    } t_dec_in;

    typedef struct packed {
        logic [4:0]         op_class;
        logic [2:0]         operand_form;
        logic signed [63:0] immediate;
        logic [5:0]         dest_reg;
        logic               dest_is_base;
        logic [5:0]         src_reg;
        logic               src_is_base;
        logic [3:0]         sched_flags;
        logic [1:0]         pred_mode;
        logic               decode_ok;
        logic [47:0]        pc_out;
    } t_dec_out;

endpackage

// ===== rtl/twid_cfg.sv =====
// APB configuration register block holding the xg3 mode bit.
module twid_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twid_pkg::PADDR_W-1:0] paddr,
    input  logic [twid_pkg::PDATA_W-1:0] pwdata,
    output logic [twid_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic                         o_xg3_mode
);
    import twid_pkg::*;

    logic r_xg3_mode;
    logic hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_XG3_MODE);
    assign pready = 1'b1;
    assign prdata = hit ? {{(PDATA_W-1){1'b0}}, r_xg3_mode} : '0;
    assign o_xg3_mode = r_xg3_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xg3_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_xg3_mode <= pwdata[0];
        end
    end

endmodule

// ===== rtl/twid_decode.sv =====
// Combinational decode of one registered two-word instruction.
module twid_decode (
    input  logic               i_xg3_mode,
    input  twid_pkg::t_dec_in  i_item,
    output twid_pkg::t_dec_out o_res
);
    import twid_pkg::*;

    logic [15:0] w1;
    logic [15:0] w2;
    logic [31:0] jb;
    logic [5:0]  rn;
    logic        wm;
    logic        wi;
    logic        jumbo;
    logic [1:0]  sub;
    logic [63:0] iu;
    logic [63:0] in_neg;
    logic [63:0] is;
    logic [63:0] ib;
    logic [62:0] ib_x;
    logic [4:0]  cls;
    logic [2:0]  form;
    logic [63:0] imm;
    logic [5:0]  dr;
    logic        db;
    logic [5:0]  sr;
    logic        sb;
    logic [3:0]  fl;
    logic        ok;

    assign w1    = i_item.first_word;
    assign w2    = i_item.second_word;
    assign jb    = i_item.jumbo_bits;
    assign rn    = {jb[30], w1[4:0]};
    assign wm    = jb[29];
    assign wi    = jb[28];
    assign jumbo = jb[25];
    assign sub   = jb[21:20];

    // Pre-scaled 22-bit form: sign from wi, then scale by two and back off one word
    assign ib_x = {{41{wi}}, rn, w2};

    always_comb begin
        // 20-bit branch form, with the three bits just above it flipped by the prefix
        ib = {{44{w1[3]}}, w1[3:0], w2};
        ib[22:20] = ib[22:20] ^ jb[30:28];
        if (i_xg3_mode) begin
            ib = {ib_x, 1'b0} - 64'd2;
        end

        if (jumbo) begin
            is     = {{32{wi}}, jb[15:0], w2};
            iu     = is;
            in_neg = is;
        end else begin
            is     = {{48{w2[15]}}, w2};
            iu     = {48'd0, w2};
            in_neg = {{48{1'b1}}, w2};
        end

        cls  = CLS_INVALID;
        form = FORM_NONE;
        imm  = '0;
        dr   = '0;
        db   = 1'b0;
        sr   = '0;
        sb   = 1'b0;
        fl   = FL_NONE;
        ok   = 1'b1;

        case (w1[7:4])
            4'h0, 4'h1: begin
                cls = CLS_LDI; form = FORM_IMM_REG; imm = iu; dr = rn;
            end
            4'h2, 4'h3: begin
                cls = CLS_LDI; form = FORM_IMM_REG; imm = in_neg; dr = rn;
            end
            4'h4, 4'h5: begin
                cls  = (jumbo && sub == 2'd3) ? CLS_XMOVTT : CLS_ADD;
                form = FORM_IMM_REG; imm = is; dr = rn;
            end
            4'h6, 4'h7: begin
                cls = CLS_LDISH16; form = FORM_IMM_REG; imm = iu; dr = rn;
            end
            4'h8, 4'h9: begin
                cls = CLS_FLDCH; form = FORM_IMM_REG; imm = iu; dr = rn;
                if (w1[4:0] == RN_BREAK && !jb[30]) begin
                    cls = CLS_BREAK;
                end
                if (jumbo) begin
                    fl  = fl | FL_NOWEX;
                    cls = CLS_FLDCF + {3'd0, sub};
                end else if (wm) begin
                    // store form: base register is the address, rn the data
                    cls  = wi ? CLS_MOVL_ST : CLS_MOVQ_ST;
                    form = FORM_STORE;
                    dr   = '0;
                    db   = 1'b1;
                    sr   = rn;
                end
            end
            4'hA, 4'hB: begin
                cls = CLS_LEAQ; form = FORM_LOAD; imm = iu; dr = rn;
                sb  = 1'b1; fl = FL_NOWEX_IO;
                if (wm) begin
                    cls = wi ? CLS_MOVL_LD : CLS_MOVQ_LD;
                end
            end
            4'hE, 4'hF: begin
                cls = CLS_BRA; form = FORM_PC_DISP; imm = ib; fl = FL_BRANCH;
                if (i_xg3_mode ? wm : w1[4]) begin
                    cls = CLS_BSR;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        o_res.op_class     = cls;
        o_res.operand_form = form;
        o_res.immediate    = imm;
        o_res.dest_reg     = dr;
        o_res.dest_is_base = db;
        o_res.src_reg      = sr;
        o_res.src_is_base  = sb;
        o_res.sched_flags  = fl;
        o_res.pred_mode    = PRED_NONE;
        o_res.decode_ok    = ok;
        o_res.pc_out       = i_item.pc_in;

        if (i_item.predicated_form) begin
            if (!ok || w1 == 16'd0) begin
                o_res.op_class     = CLS_BREAK;
                o_res.operand_form = FORM_NONE;
                o_res.immediate    = '0;
                o_res.dest_reg     = '0;
                o_res.dest_is_base = 1'b0;
                o_res.src_reg      = '0;
                o_res.src_is_base  = 1'b0;
                o_res.sched_flags  = FL_CTRL;
            end else begin
                o_res.pred_mode = w1[10] ? PRED_FALSE : PRED_TRUE;
            end
        end
    end

endmodule

// ===== rtl/two_word_immediate_op_decoder.sv =====
// Top level: input register, decode logic and result register of the decoder.
//
// Takes one instruction per clock while o_in_stall is low and returns its decoded form
// through the input register and then the result register, with the
// whole decode between them. Both registers advance whenever the result register is
// empty or being taken, so a stall on the result side backs up into o_in_stall in the
// same cycle and no item is dropped. xg3_mode sits at APB byte address 0 and is read
// by the decode of the item in the input register; change it only while the block
// holds no item.
module two_word_immediate_op_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twid_pkg::PADDR_W-1:0] paddr,
    input  logic [twid_pkg::PDATA_W-1:0] pwdata,
    output logic [twid_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  twid_pkg::t_dec_in            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output twid_pkg::t_dec_out           o_out
);
    import twid_pkg::*;

    logic     xg3_mode;
    logic     out_load;
    logic     r_in_valid;
    t_dec_in  r_in;
    logic     r_out_valid;
    t_dec_out r_out;
    t_dec_out n_out;

    twid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_xg3_mode (xg3_mode)
    );

    twid_decode u_decode (
        .i_xg3_mode (xg3_mode),
        .i_item     (r_in),
        .o_res      (n_out)
    );

    // Result register frees up when empty or when its transfer completes
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/twid_checker.sv =====
// Port-level checks for the decoder and the bind that attaches them.
module twid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input twid_pkg::t_dec_out o_out
);
    import twid_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Failed decode only ever shows as invalid or break
    a_fail_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.decode_ok |->
            (o_out.op_class == CLS_INVALID || o_out.op_class == CLS_BREAK)
            && o_out.pred_mode == PRED_NONE)
        else $error("failed decode with live operation");

    // Branches carry branch flags and no destination
    a_branch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.operand_form == FORM_PC_DISP |->
            o_out.sched_flags == FL_BRANCH && o_out.dest_reg == 6'd0
            && (o_out.op_class == CLS_BRA || o_out.op_class == CLS_BSR))
        else $error("malformed branch result");

endmodule

bind two_word_immediate_op_decoder twid_checker u_twid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
